@@ hw/rtl/particle_contact_resolver_unit_defines.svh @@
`ifndef PARTICLE_CONTACT_RESOLVER_UNIT_DEFINES_SVH
`define PARTICLE_CONTACT_RESOLVER_UNIT_DEFINES_SVH

// Checks that a condition implies a property in the same cycle.
`define PCR_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("contact resolver check failed");

// Checks that a condition implies a property in the following cycle.
`define PCR_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("contact resolver check failed");

`endif

@@ hw/rtl/pcr_pkg.sv @@
`timescale 1ns / 1ps

package pcr_pkg;

  localparam int COMPONENT_BITS = 21;
  localparam int FRAC_BITS      = 10;

  localparam int VEC_W       = 63;
  localparam int MASS_W      = 24;
  localparam int TOTAL_W     = MASS_W + 1;
  localparam int DEPTH_W     = 21;
  localparam int BOUNCE_W    = 17;
  localparam int BOUNCE_FRAC = 16;
  localparam int BOUNCE_ONE  = 1 << BOUNCE_FRAC;
  localparam int FACT_W      = BOUNCE_W + 1;

  // Control that travels alongside one contact through the pipeline.
  typedef struct packed {
    logic valid;
    logic vel_ok;
    logic pos_ok;
    logic hb;
  } side_t;

endpackage

@@ hw/rtl/particle_contact_resolver_unit.sv @@
`timescale 1ns / 1ps
// Particle contact resolver. One contact transaction is taken on every clock in
// which start is high; busy never rises, so contacts may stream back to back with
// no gaps. Each result appears on the result ports for exactly one cycle, marked by
// done. The receiver cannot hold results off, so it must take every result in the
// cycle that done is high. The pipeline is made up of the four long dividers, one
// per lane, which produce one quotient bit per stage over CB + FB + 1 pipelined
// stages, plus five stages of dot product and impulse arithmetic ahead of them and
// three stages of scaling, clamping and merging.
`include "particle_contact_resolver_unit_defines.svh"

module particle_contact_resolver_unit #(
  parameter int CB = pcr_pkg::COMPONENT_BITS,
  parameter int FB = pcr_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [pcr_pkg::VEC_W-1:0]    vel_a,
  input  logic [pcr_pkg::VEC_W-1:0]    vel_b,
  input  logic [pcr_pkg::VEC_W-1:0]    contact_normal,
  input  logic [pcr_pkg::MASS_W-1:0]   inv_mass_a,
  input  logic [pcr_pkg::MASS_W-1:0]   inv_mass_b,
  input  logic [pcr_pkg::DEPTH_W-1:0]  depth,
  input  logic [pcr_pkg::BOUNCE_W-1:0] bounce,
  input  logic                         has_b,
  output logic                         done,
  output logic [pcr_pkg::VEC_W-1:0]    dvel_a,
  output logic [pcr_pkg::VEC_W-1:0]    dvel_b,
  output logic [pcr_pkg::VEC_W-1:0]    move_a,
  output logic [pcr_pkg::VEC_W-1:0]    move_b,
  output logic                         vel_applied,
  output logic                         pos_applied,
  output logic                         saturated
);

  localparam int QW  = CB + FB + 1;
  localparam int NW  = QW + pcr_pkg::MASS_W;
  // Lane pipeline: the divider stages, then one multiply and one clamp stage.
  localparam int LAT = QW + 2;

  pcr_pkg::side_t                side_f;
  pcr_pkg::side_t                sd [LAT+1];
  logic [NW-1:0]                 num_va, num_vb, num_pa, num_pb;
  logic [pcr_pkg::TOTAL_W-1:0]   total;
  logic [3*CB-1:0]               nrm;
  logic [3*CB-1:0]               vec_va, vec_vb, vec_pa, vec_pb;
  logic                          sat_va, sat_vb, sat_pa, sat_pb;
  logic                          use_va, use_vb, use_pa, use_pb;

  // Every contact is independent, so the block never pushes back.
  assign busy = 1'b0;

  pcr_front #(.CB(CB), .FB(FB)) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (start),
    .vel_a          (vel_a),
    .vel_b          (vel_b),
    .contact_normal (contact_normal),
    .inv_mass_a     (inv_mass_a),
    .inv_mass_b     (inv_mass_b),
    .depth          (depth),
    .bounce         (bounce),
    .has_b          (has_b),
    .side           (side_f),
    .num_va         (num_va),
    .num_vb         (num_vb),
    .num_pa         (num_pa),
    .num_pb         (num_pb),
    .total          (total),
    .nrm            (nrm)
  );

  // Four lanes: impulse on A and B, and penetration correction on A and B. The B
  // lanes push along the reversed normal.
  pcr_lane #(.CB(CB), .FB(FB), .NEG(1'b0)) u_lane_va (
    .clk (clk), .num (num_va), .den (total), .nrm (nrm), .vec (vec_va), .sat (sat_va)
  );
  pcr_lane #(.CB(CB), .FB(FB), .NEG(1'b1)) u_lane_vb (
    .clk (clk), .num (num_vb), .den (total), .nrm (nrm), .vec (vec_vb), .sat (sat_vb)
  );
  pcr_lane #(.CB(CB), .FB(FB), .NEG(1'b0)) u_lane_pa (
    .clk (clk), .num (num_pa), .den (total), .nrm (nrm), .vec (vec_pa), .sat (sat_pa)
  );
  pcr_lane #(.CB(CB), .FB(FB), .NEG(1'b1)) u_lane_pb (
    .clk (clk), .num (num_pb), .den (total), .nrm (nrm), .vec (vec_pb), .sat (sat_pb)
  );

  // The control side of each transaction is delayed to meet its lane results.
  assign sd[0] = side_f;

  for (genvar i = 0; i < LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1] <= '0;
      end else begin
        sd[i+1] <= sd[i];
      end
    end
  end

  // Merge: a lane counts only when its correction applies; otherwise its
  // vector is zero and its saturation flag is ignored.
  always_comb begin
    use_va = sd[LAT].valid && sd[LAT].vel_ok;
    use_vb = use_va && sd[LAT].hb;
    use_pa = sd[LAT].valid && sd[LAT].pos_ok;
    use_pb = use_pa && sd[LAT].hb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      vel_applied <= 1'b0;
      pos_applied <= 1'b0;
      saturated   <= 1'b0;
    end else begin
      done        <= sd[LAT].valid;
      vel_applied <= use_va;
      pos_applied <= use_pa;
      saturated   <= (use_va && sat_va) || (use_vb && sat_vb) ||
                     (use_pa && sat_pa) || (use_pb && sat_pb);
    end
  end

  always_ff @(posedge clk) begin
    dvel_a <= use_va ? pcr_pkg::VEC_W'(vec_va) : '0;
    dvel_b <= use_vb ? pcr_pkg::VEC_W'(vec_vb) : '0;
    move_a <= use_pa ? pcr_pkg::VEC_W'(vec_pa) : '0;
    move_b <= use_pb ? pcr_pkg::VEC_W'(vec_pb) : '0;
  end

  `PCR_ASSERT_IMP(a_no_impulse, done && !vel_applied, dvel_a == '0 && dvel_b == '0)
  `PCR_ASSERT_IMP(a_no_move, done && !pos_applied, move_a == '0 && move_b == '0)
  `PCR_ASSERT_IMP(a_sat_cause, saturated, done && (vel_applied || pos_applied))

endmodule

@@ hw/rtl/pcr_front.sv @@
`timescale 1ns / 1ps

module pcr_front #(
  parameter int CB = pcr_pkg::COMPONENT_BITS,
  parameter int FB = pcr_pkg::FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic [pcr_pkg::VEC_W-1:0]       vel_a,
  input  logic [pcr_pkg::VEC_W-1:0]       vel_b,
  input  logic [pcr_pkg::VEC_W-1:0]       contact_normal,
  input  logic [pcr_pkg::MASS_W-1:0]      inv_mass_a,
  input  logic [pcr_pkg::MASS_W-1:0]      inv_mass_b,
  input  logic [pcr_pkg::DEPTH_W-1:0]     depth,
  input  logic [pcr_pkg::BOUNCE_W-1:0]    bounce,
  input  logic                            has_b,
  output pcr_pkg::side_t                  side,
  output logic [CB+FB+1+pcr_pkg::MASS_W-1:0] num_va,
  output logic [CB+FB+1+pcr_pkg::MASS_W-1:0] num_vb,
  output logic [CB+FB+1+pcr_pkg::MASS_W-1:0] num_pa,
  output logic [CB+FB+1+pcr_pkg::MASS_W-1:0] num_pb,
  output logic [pcr_pkg::TOTAL_W-1:0]     total,
  output logic [3*CB-1:0]                 nrm
);

  localparam int DW  = CB + 1;
  localparam int PW  = DW + CB;
  localparam int SVW = PW + 2;
  localparam int FW  = pcr_pkg::FACT_W;
  localparam int UW  = SVW + FW;
  localparam int QW  = CB + FB + 1;
  localparam int NW  = QW + pcr_pkg::MASS_W;
  localparam int SH  = FB + pcr_pkg::BOUNCE_FRAC;
  localparam int MW  = pcr_pkg::MASS_W;
  localparam int TW  = pcr_pkg::TOTAL_W;

  // stage 1
  logic                   v1, hb1;
  logic signed [DW-1:0]   d1 [3];
  logic [3*CB-1:0]        n1;
  logic [MW-1:0]          ima1, imb1;
  logic signed [CB-1:0]   dep1;
  logic [pcr_pkg::BOUNCE_W-1:0] e1;
  // stage 2
  logic                   v2, hb2;
  logic signed [PW-1:0]   p2 [3];
  logic [3*CB-1:0]        n2;
  logic [MW-1:0]          ima2, imb2;
  logic [TW-1:0]          tot2;
  logic signed [CB-1:0]   dep2;
  logic [pcr_pkg::BOUNCE_W-1:0] e2;
  // stage 3
  logic                   v3, hb3;
  logic signed [SVW-1:0]  sv3;
  logic [3*CB-1:0]        n3;
  logic [MW-1:0]          ima3, imb3;
  logic [TW-1:0]          tot3;
  logic signed [CB-1:0]   dep3;
  logic [pcr_pkg::BOUNCE_W-1:0] e3;
  // stage 4
  logic                   v4, hb4, vok4, pok4;
  logic [UW-1:0]          u4;
  logic [QW-1:0]          pv4;
  logic [3*CB-1:0]        n4;
  logic [MW-1:0]          ima4, imb4;
  logic [TW-1:0]          tot4;

  logic [SVW-1:0]         mag3;
  logic [FW-1:0]          fac3;
  logic [UW-1:0]          tsh4, tcap4;
  logic [QW-1:0]          t4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      side <= '0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      side.valid <= v4;
      side.vel_ok <= vok4;
      side.pos_ok <= pok4;
      side.hb <= hb4;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d1[k] <= has_b ?
               (DW'($signed(vel_a[k*CB +: CB])) - DW'($signed(vel_b[k*CB +: CB]))) :
               DW'($signed(vel_a[k*CB +: CB]));
      p2[k] <= PW'(d1[k]) * PW'($signed(n1[k*CB +: CB]));
    end
    n1   <= contact_normal[3*CB-1:0];
    ima1 <= inv_mass_a;
    imb1 <= has_b ? inv_mass_b : '0;
    dep1 <= $signed(depth[CB-1:0]);
    e1   <= bounce;
    hb1  <= has_b;

    tot2 <= TW'(ima1) + TW'(imb1);
    n2   <= n1;
    ima2 <= ima1;
    imb2 <= imb1;
    dep2 <= dep1;
    e2   <= e1;
    hb2  <= hb1;

    sv3  <= SVW'(p2[0]) + SVW'(p2[1]) + SVW'(p2[2]);
    n3   <= n2;
    ima3 <= ima2;
    imb3 <= imb2;
    tot3 <= tot2;
    dep3 <= dep2;
    e3   <= e2;
    hb3  <= hb2;

    u4   <= UW'(mag3) * UW'(fac3);
    vok4 <= (sv3 <= 0) && (tot3 != '0);
    pok4 <= (dep3 > 0) && (tot3 != '0);
    pv4  <= QW'($unsigned(dep3));
    n4   <= n3;
    ima4 <= ima3;
    imb4 <= imb3;
    tot4 <= tot3;
    hb4  <= hb3;

    num_va <= NW'(t4) * NW'(ima4);
    num_vb <= NW'(t4) * NW'(imb4);
    num_pa <= NW'(pv4) * NW'(ima4);
    num_pb <= NW'(pv4) * NW'(imb4);
    total  <= tot4;
    nrm    <= n4;
  end

  always_comb begin
    mag3  = $unsigned(-sv3);
    fac3  = FW'(pcr_pkg::BOUNCE_ONE) + FW'(e3);
    tsh4  = u4 >> SH;
    tcap4 = (tsh4 > (UW'(1) << (QW - 1))) ? (UW'(1) << (QW - 1)) : tsh4;
    t4    = tcap4[QW-1:0];
  end

endmodule

@@ hw/rtl/pcr_lane.sv @@
`timescale 1ns / 1ps

module pcr_lane #(
  parameter int CB  = pcr_pkg::COMPONENT_BITS,
  parameter int FB  = pcr_pkg::FRAC_BITS,
  parameter bit NEG = 1'b0
) (
  input  logic                               clk,
  input  logic [CB+FB+1+pcr_pkg::MASS_W-1:0] num,
  input  logic [pcr_pkg::TOTAL_W-1:0]        den,
  input  logic [3*CB-1:0]                    nrm,
  output logic [3*CB-1:0]                    vec,
  output logic                               sat
);

  localparam int QW = CB + FB + 1;
  localparam int TW = pcr_pkg::TOTAL_W;
  localparam int MW = pcr_pkg::MASS_W;
  localparam int RW = CB + QW;
  localparam int XW = RW - FB;

  // One quotient bit per stage; z shifts dividend bits out and quotient bits in.
  logic [TW-1:0]   rem [QW+1];
  logic [QW-1:0]   z   [QW+1];
  logic [TW-1:0]   dsr [QW+1];
  logic [3*CB-1:0] nr  [QW+1];
  logic [TW:0]     sh  [QW];
  logic            ge  [QW];

  logic [RW-1:0]   prod [3];
  logic            ng   [3];
  logic [CB-1:0]   mag  [3];
  logic [XW-1:0]   m    [3];
  logic            st   [3];
  logic [CB-1:0]   comp [3];
  logic [XW-1:0]   cmax, lim;

  assign rem[0] = TW'(num[QW +: MW]);
  assign z[0]   = num[QW-1:0];
  assign dsr[0] = den;
  assign nr[0]  = nrm;

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      sh[i] = {rem[i], z[i][QW-1]};
      ge[i] = sh[i] >= {1'b0, dsr[i]};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    always_ff @(posedge clk) begin
      rem[i+1] <= ge[i] ? TW'(sh[i] - {1'b0, dsr[i]}) : sh[i][TW-1:0];
      z[i+1]   <= {z[i][QW-2:0], ge[i]};
      dsr[i+1] <= dsr[i];
      nr[i+1]  <= nr[i];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = nr[QW][k*CB+CB-1] ? CB'(-nr[QW][k*CB +: CB]) : nr[QW][k*CB +: CB];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod[k] <= RW'(mag[k]) * RW'(z[QW]);
      ng[k]   <= nr[QW][k*CB+CB-1] ^ NEG;
    end
  end

  always_comb begin
    cmax = (XW'(1) << (CB - 1)) - XW'(1);
    lim  = XW'(1) << (CB - 1);
    for (int k = 0; k < 3; k++) begin
      m[k]  = XW'(prod[k] >> FB);
      st[k] = ng[k] ? (m[k] > lim) : (m[k] > cmax);
      if (ng[k]) begin
        comp[k] = st[k] ? lim[CB-1:0] : CB'(-m[k][CB-1:0]);
      end else begin
        comp[k] = st[k] ? cmax[CB-1:0] : m[k][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    vec <= {comp[2], comp[1], comp[0]};
    sat <= st[0] | st[1] | st[2];
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the particle contact resolver.
// Contacts are driven on the falling edge and every accepted transaction is
// predicted at the rising edge on which it is taken. Results are compared, field
// by field, with the oldest prediction on each rising edge at which done is high.
module tb_top;
  import pcr_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam longint signed COMP_MAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint signed COMP_MIN = -COMP_MAX - 1;
  localparam longint unsigned IMPULSE_CAP = 64'd1 << (CB + FRAC_BITS);
  localparam int RANDOM_CONTACTS = 1750;
  localparam int SETTLE_CYCLES = 80;

  // One contact as it is driven onto the input ports.
  typedef struct {
    logic [VEC_W-1:0]    vel_a;
    logic [VEC_W-1:0]    vel_b;
    logic [VEC_W-1:0]    normal;
    logic [MASS_W-1:0]   inv_mass_a;
    logic [MASS_W-1:0]   inv_mass_b;
    logic [DEPTH_W-1:0]  depth;
    logic [BOUNCE_W-1:0] bounce;
    logic                has_b;
  } contact_t;

  // One resolved contact as it appears on the result ports.
  typedef struct {
    logic [VEC_W-1:0] dvel_a;
    logic [VEC_W-1:0] dvel_b;
    logic [VEC_W-1:0] move_a;
    logic [VEC_W-1:0] move_b;
    logic             vel_applied;
    logic             pos_applied;
    logic             saturated;
  } response_t;

  // A row of the directed table; known marks a row whose response is typed in.
  typedef struct {
    contact_t  c;
    bit        known;
    response_t r;
  } table_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  logic [VEC_W-1:0] vel_a, vel_b, contact_normal;
  logic [VEC_W-1:0] dvel_a, dvel_b, move_a, move_b;
  logic [MASS_W-1:0] inv_mass_a, inv_mass_b;
  logic [DEPTH_W-1:0] depth;
  logic [BOUNCE_W-1:0] bounce;
  logic has_b;
  logic vel_applied, pos_applied, saturated;

  response_t pending_responses[$];
  table_row_t contact_table[$];
  int accepted_count;
  int error_count;
  bit idling_on;
  // The response typed in for the contact now on the ports, if there is one.
  bit        driven_known;
  response_t driven_response;

  particle_contact_resolver_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vel_a(vel_a), .vel_b(vel_b), .contact_normal(contact_normal),
    .inv_mass_a(inv_mass_a), .inv_mass_b(inv_mass_b), .depth(depth),
    .bounce(bounce), .has_b(has_b), .done(done),
    .dvel_a(dvel_a), .dvel_b(dvel_b), .move_a(move_a), .move_b(move_b),
    .vel_applied(vel_applied), .pos_applied(pos_applied), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A hard stop, well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint signed sign_extend(logic [CB-1:0] v);
    return $signed(v);
  endfunction

  function automatic logic [VEC_W-1:0] pack_vec(longint signed x, longint signed y,
                                                 longint signed z);
    logic [CB-1:0] xs, ys, zs;
    xs = x[CB-1:0];
    ys = y[CB-1:0];
    zs = z[CB-1:0];
    return {zs, ys, xs};
  endfunction

  // Scales each normal component by a magnitude, rounding toward zero, then
  // clamps it. The sign is flipped for body B.
  function automatic logic [VEC_W-1:0] scale_normal(longint signed n[3],
      longint unsigned factor, bit flip, inout bit clamped);
    logic [VEC_W-1:0] w;
    longint unsigned mag;
    longint signed v;
    w = '0;
    for (int k = 0; k < 3; k++) begin
      mag = (n[k] < 0) ? longint'(-n[k]) : longint'(n[k]);
      v = longint'((mag * factor) >> FRAC_BITS);
      if ((n[k] < 0) != flip) v = -v;
      if (v > COMP_MAX) begin
        v = COMP_MAX;
        clamped = 1'b1;
      end
      if (v < COMP_MIN) begin
        v = COMP_MIN;
        clamped = 1'b1;
      end
      w[k*CB +: CB] = v[CB-1:0];
    end
    return w;
  endfunction

  // Works out the impulse and the penetration correction for one contact.
  function automatic response_t resolve_contact(contact_t c);
    longint signed va[3], vb[3], n[3];
    longint signed closing, pen;
    longint unsigned ima, imb, total, impulse, bounce_f, pen_u;
    bit clamped;
    response_t r;
    r = '{default: '0};
    clamped = 1'b0;
    closing = 0;
    for (int k = 0; k < 3; k++) begin
      va[k] = sign_extend(c.vel_a[k*CB +: CB]);
      vb[k] = c.has_b ? sign_extend(c.vel_b[k*CB +: CB]) : 0;
      n[k]  = sign_extend(c.normal[k*CB +: CB]);
      closing += (va[k] - vb[k]) * n[k];
    end
    ima = c.inv_mass_a;
    imb = c.has_b ? longint'(c.inv_mass_b) : 0;
    total = ima + imb;
    pen = sign_extend(c.depth);
    bounce_f = c.bounce;
    if (total == 0) return r;
    if (closing <= 0) begin
      impulse = (longint'(-closing) * (64'd65536 + bounce_f)) >> (FRAC_BITS + 16);
      if (impulse > IMPULSE_CAP) impulse = IMPULSE_CAP;
      r.dvel_a = scale_normal(n, (impulse * ima) / total, 1'b0, clamped);
      if (c.has_b) r.dvel_b = scale_normal(n, (impulse * imb) / total, 1'b1, clamped);
      r.vel_applied = 1'b1;
    end
    if (pen > 0) begin
      pen_u = pen;
      r.move_a = scale_normal(n, (pen_u * ima) / total, 1'b0, clamped);
      if (c.has_b) r.move_b = scale_normal(n, (pen_u * imb) / total, 1'b1, clamped);
      r.pos_applied = 1'b1;
    end
    r.saturated = clamped;
    return r;
  endfunction

  function automatic longint signed random_component();
    case ($urandom_range(5))
      0: return COMP_MAX;
      1: return COMP_MIN;
      2: return $signed($urandom_range(2048)) - 1024;
      3: return $signed($urandom_range(32768)) - 16384;
      default: return sign_extend($urandom);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] random_vec();
    return pack_vec(random_component(), random_component(), random_component());
  endfunction

  function automatic logic [MASS_W-1:0] random_mass();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1 << 17);
      default: return $urandom;
    endcase
  endfunction

  // The depth is mostly a genuine overlap from zero to COMP_MAX; the rest is unconstrained.
  function automatic contact_t random_contact();
    contact_t c;
    c.vel_a = random_vec();
    c.vel_b = random_vec();
    c.normal = random_vec();
    c.inv_mass_a = random_mass();
    c.inv_mass_b = random_mass();
    c.has_b = $urandom_range(1);
    if ($urandom_range(99) < 60) c.depth = $urandom_range(COMP_MAX);
    else c.depth = $urandom;
    if ($urandom_range(3) == 0) c.bounce = $urandom;
    else c.bounce = $urandom_range(BOUNCE_ONE);
    return c;
  endfunction

  function automatic contact_t make_contact(logic [VEC_W-1:0] va, logic [VEC_W-1:0] vb,
      logic [VEC_W-1:0] n, logic [MASS_W-1:0] ima, logic [MASS_W-1:0] imb,
      logic [DEPTH_W-1:0] dep, logic [BOUNCE_W-1:0] e, logic hb);
    contact_t c;
    c.vel_a = va;
    c.vel_b = vb;
    c.normal = n;
    c.inv_mass_a = ima;
    c.inv_mass_b = imb;
    c.depth = dep;
    c.bounce = e;
    c.has_b = hb;
    return c;
  endfunction

  task automatic add_row(contact_t c, bit known, response_t r);
    table_row_t row;
    row.c = c;
    row.known = known;
    row.r = r;
    contact_table.push_back(row);
  endtask

  // Drives one contact at the falling edge and holds it until it is taken.
  task automatic send_contact(contact_t c, bit known, response_t r);
    int taken;
    while (idling_on && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(negedge clk);
    end
    vel_a <= c.vel_a;
    vel_b <= c.vel_b;
    contact_normal <= c.normal;
    inv_mass_a <= c.inv_mass_a;
    inv_mass_b <= c.inv_mass_b;
    depth <= c.depth;
    bounce <= c.bounce;
    has_b <= c.has_b;
    start <= 1'b1;
    driven_known = known;
    driven_response = r;
    taken = accepted_count;
    do @(negedge clk); while (accepted_count == taken);
  endtask

  task automatic check_field(string name, logic [VEC_W-1:0] exp_v, logic [VEC_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Takes each accepted transaction and checks each result on the edge that
  // ends its cycle.
  always @(posedge clk) begin
    contact_t c;
    response_t e;
    if (!rst) begin
      if (start && !busy) begin
        c = make_contact(vel_a, vel_b, contact_normal, inv_mass_a, inv_mass_b,
                         depth, bounce, has_b);
        pending_responses.push_back(driven_known ? driven_response : resolve_contact(c));
        accepted_count++;
      end
      if (done) begin
        if (pending_responses.size() == 0) begin
          $error("result transaction arrived with none outstanding");
          error_count++;
        end else begin
          e = pending_responses.pop_front();
          check_field("dvel_a", e.dvel_a, dvel_a);
          check_field("dvel_b", e.dvel_b, dvel_b);
          check_field("move_a", e.move_a, move_a);
          check_field("move_b", e.move_b, move_b);
          check_field("vel_applied", e.vel_applied, vel_applied);
          check_field("pos_applied", e.pos_applied, pos_applied);
          check_field("saturated", e.saturated, saturated);
        end
      end
    end
  end

  initial begin
    response_t none, r;
    logic [VEC_W-1:0] unit_x;
    none = '{default: '0};
    unit_x = pack_vec(1024, 0, 0);
    rst = 1'b1;
    start = 1'b0;
    vel_a = '0;
    vel_b = '0;
    contact_normal = '0;
    inv_mass_a = '0;
    inv_mass_b = '0;
    depth = '0;
    bounce = '0;
    has_b = 1'b0;
    driven_known = 1'b0;
    driven_response = none;
    accepted_count = 0;
    error_count = 0;
    idling_on = 1'b1;

    // With no mass to move, every output stays at zero.
    add_row(make_contact('0, '0, '0, '0, '0, '0, '0, 1'b0), 1'b1, none);
    add_row(make_contact(random_vec(), random_vec(), unit_x, '0, '1, 21'd500,
                         17'd65536, 1'b0), 1'b1, none);
    add_row(make_contact(random_vec(), random_vec(), random_vec(), '0, '0, 21'd900,
                         17'd100, 1'b1), 1'b1, none);
    // A resting wall contact along x: the whole depth goes to A.
    r = none;
    r.move_a = pack_vec(100, 0, 0);
    r.vel_applied = 1'b1;
    r.pos_applied = 1'b1;
    add_row(make_contact('0, '0, unit_x, 24'd65536, '0, 21'd100, '0, 1'b0), 1'b1, r);
    // Separating wall contact.
    add_row(make_contact(unit_x, '0, unit_x, 24'd65536, '0, 21'd50, 17'd65536, 1'b0),
            1'b0, none);
    // Head-on pairs: equal masses with full restitution, then unequal masses with above-one restitution.
    add_row(make_contact(pack_vec(-2048, 0, 0), pack_vec(2048, 0, 0), unit_x, 24'd65536,
                         24'd65536, 21'd64, 17'd65536, 1'b1), 1'b0, none);
    add_row(make_contact(pack_vec(-2048, 300, 0), pack_vec(2048, 0, -7), unit_x, 24'd65536,
                         24'd131072, 21'd64, 17'h1FFFF, 1'b1), 1'b0, none);
    // Extremes that drive lanes into clamping.
    add_row(make_contact(pack_vec(COMP_MIN, COMP_MIN, COMP_MIN),
                         pack_vec(COMP_MAX, COMP_MAX, COMP_MAX),
                         pack_vec(COMP_MAX, COMP_MAX, COMP_MAX), '1, '1, COMP_MAX[20:0],
                         '0, 1'b1), 1'b0, none);
    add_row(make_contact(pack_vec(COMP_MAX, COMP_MAX, COMP_MAX), '1,
                         pack_vec(COMP_MIN, COMP_MIN, COMP_MIN), '1, 24'd1, COMP_MAX[20:0],
                         17'h1FFFF, 1'b0), 1'b0, none);
    add_row(make_contact(pack_vec(COMP_MIN, COMP_MAX, COMP_MIN),
                         pack_vec(COMP_MAX, COMP_MIN, COMP_MAX),
                         pack_vec(COMP_MIN, COMP_MAX, COMP_MIN), 24'd1, '1, '1,
                         17'h1FFFF, 1'b1), 1'b0, none);
    // Depth at the negative extreme, minus one, zero and one.
    add_row(make_contact(unit_x, '0, unit_x, '1, '0, 21'h100000, '0, 1'b0), 1'b0, none);
    add_row(make_contact('0, unit_x, unit_x, '1, '1, '1, '0, 1'b1), 1'b0, none);
    add_row(make_contact('0, unit_x, unit_x, '1, '1, '0, '0, 1'b1), 1'b0, none);
    add_row(make_contact('0, unit_x, unit_x, '1, '1, 21'd1, '0, 1'b1), 1'b0, none);
    // Only B carries mass.
    add_row(make_contact(pack_vec(-5000, 77, 3), pack_vec(900, -1, 0),
                         pack_vec(700, -700, 10), '0, '1, 21'd3000, 17'd32768, 1'b1),
            1'b0, none);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (contact_table[i])
      send_contact(contact_table[i].c, contact_table[i].known, contact_table[i].r);

    for (int i = 0; i < RANDOM_CONTACTS; i++) begin
      // A stretch of back-to-back contacts, and one full drain half way.
      idling_on = !(i >= 600 && i < 900);
      if (i == RANDOM_CONTACTS / 2) begin
        start <= 1'b0;
        while (pending_responses.size() != 0) @(negedge clk);
      end
      send_contact(random_contact(), 1'b0, none);
    end
    start <= 1'b0;

    while (pending_responses.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pcr_pkg.sv
hw/rtl/pcr_front.sv
hw/rtl/pcr_lane.sv
hw/rtl/particle_contact_resolver_unit.sv
test/tb_top.sv
